// ===== hw/rtl/lru_pkg.sv =====
// Shared constants and types for the LRU page replacement block.
`timescale 1ns / 1ps

package lru_pkg;

    localparam int FRAMES    = 4;
    localparam int PAGE_BITS = 16;

    // fixed field widths
    localparam int PAGE_W  = 16;
    localparam int FAULT_W = 16;
    localparam int CFG_W   = 3;

    // derived widths
    localparam int SP_W   = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam int RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int LIM_W  = $clog2(FRAMES + 1);

    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};
    localparam logic [CFG_W-1:0]   FIU_RESET = CFG_W'(3);

    // register indexes
    localparam logic REG_FRAMES_IN_USE = 1'b0;

    typedef struct packed {
        logic [LIM_W-1:0] limit;  // active frame count, 1 .. FRAMES
        logic             flush;  // invalidate all frames this cycle
    } t_cfg;

endpackage

// ===== hw/rtl/lru_cfg.sv =====
// APB register file: frames_in_use and the derived active frame limit.
`timescale 1ns / 1ps

module lru_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output lru_pkg::t_cfg  o_cfg
);
    import lru_pkg::*;

    logic [CFG_W-1:0] r_fiu;
    logic             r_flush;
    logic             wr_en;
    logic [LIM_W-1:0] lim;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_FRAMES_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fiu   <= FIU_RESET;
            r_flush <= 1'b0;
        end else begin
            r_flush <= wr_en;
            if (wr_en) begin
                r_fiu <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        if (r_fiu == '0) begin
            lim = LIM_W'(1);
        end else if (32'(r_fiu) > 32'(FRAMES)) begin
            lim = LIM_W'(FRAMES);
        end else begin
            lim = LIM_W'(r_fiu);
        end
    end

    assign prdata = (paddr[2] == REG_FRAMES_IN_USE) ? 32'(r_fiu) : 32'd0;

    assign o_cfg.limit = lim;
    assign o_cfg.flush = r_flush;

endmodule

// ===== hw/rtl/lru_core.sv =====
// Frame table, hit/free/victim search, rank update and result register.
`timescale 1ns / 1ps

module lru_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lru_pkg::t_cfg               i_cfg,
    input  logic                        i_valid,
    input  logic [lru_pkg::PAGE_W-1:0]  i_page,
    output logic                        o_done,
    output logic                        o_hit,
    output logic                        o_evicted_valid,
    output logic [lru_pkg::PAGE_W-1:0]  o_evicted_page,
    output logic [lru_pkg::FAULT_W-1:0] o_fault_count
);
    import lru_pkg::*;

    logic [SP_W-1:0]    r_page  [FRAMES];
    logic [FRAMES-1:0]  r_fvalid;
    logic [RANK_W-1:0]  r_rank  [FRAMES];
    logic [FAULT_W-1:0] r_faults;

    logic [FRAMES-1:0]  n_fvalid;
    logic [RANK_W-1:0]  n_rank  [FRAMES];
    logic [FAULT_W-1:0] n_faults;

    logic               r_done;
    logic               r_hit;
    logic               r_ev_valid;
    logic [SP_W-1:0]    r_ev_page;

    logic               hit_found, free_found, vic_found;
    logic [RANK_W-1:0]  hit_slot, free_slot, vic_slot, slot;
    logic [RANK_W-1:0]  bound, vic_rank;
    logic               age_all;
    logic               write_page;
    logic [SP_W-1:0]    pg;

    assign pg       = i_page[SP_W-1:0];
    assign vic_rank = RANK_W'(i_cfg.limit - 1'b1);

    // With every active frame valid the ranks are 0 .. limit-1, so the
    // victim is the frame holding the oldest rank.
    always_comb begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        vic_found  = 1'b0;
        hit_slot   = '0;
        free_slot  = '0;
        vic_slot   = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (LIM_W'(i) < i_cfg.limit) begin
                if (r_fvalid[i]) begin
                    if (!hit_found && r_page[i] == pg) begin
                        hit_found = 1'b1;
                        hit_slot  = RANK_W'(i);
                    end
                    if (!vic_found && r_rank[i] == vic_rank) begin
                        vic_found = 1'b1;
                        vic_slot  = RANK_W'(i);
                    end
                end else if (!free_found) begin
                    free_found = 1'b1;
                    free_slot  = RANK_W'(i);
                end
            end
        end
    end

    always_comb begin
        priority if (hit_found) begin
            slot = hit_slot;
        end else if (free_found) begin
            slot = free_slot;
        end else begin
            slot = vic_slot;
        end
    end

    assign bound      = r_rank[slot];
    assign age_all    = !hit_found && free_found;
    assign write_page = i_valid && !hit_found && (free_found || vic_found);

    always_comb begin
        n_fvalid = r_fvalid;
        n_rank   = r_rank;
        n_faults = r_faults;
        if (i_valid) begin
            if (!hit_found && r_faults != FAULT_MAX) begin
                n_faults = r_faults + 1'b1;
            end
            if (hit_found || free_found || vic_found) begin
                for (int i = 0; i < FRAMES; i++) begin
                    if (LIM_W'(i) < i_cfg.limit && r_fvalid[i] && RANK_W'(i) != slot
                        && (age_all || r_rank[i] < bound)) begin
                        n_rank[i] = r_rank[i] + 1'b1;
                    end
                end
                n_rank[slot]   = '0;
                n_fvalid[slot] = 1'b1;
            end
        end
        if (i_cfg.flush) begin
            n_fvalid = '0;
            for (int i = 0; i < FRAMES; i++) begin
                n_rank[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvalid <= '0;
            r_faults <= '0;
            r_done   <= 1'b0;
            for (int i = 0; i < FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_fvalid <= n_fvalid;
            r_faults <= n_faults;
            r_rank   <= n_rank;
            r_done   <= i_valid;
        end
    end

    // page table and result payload, no reset
    always_ff @(posedge i_clk) begin
        if (write_page) begin
            r_page[slot] <= pg;
        end
        if (i_valid) begin
            r_hit      <= hit_found;
            r_ev_valid <= !hit_found && !free_found && vic_found;
            r_ev_page  <= (!hit_found && !free_found && vic_found) ? r_page[vic_slot] : '0;
        end
    end

    assign o_done          = r_done;
    assign o_hit           = r_hit;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_page  = PAGE_W'(r_ev_page);
    assign o_fault_count   = r_faults;

endmodule

// ===== hw/rtl/lru_page_replacement.sv =====
// Top level: input register, configuration port and LRU frame core.
// A page accepted into the input register goes on to the core's result
// register, where o_done marks its result for one cycle;
// the receiver cannot stall.
// Throughput: one page per cycle, as the frame search and rank update in the
// core are combinational; busy stays low.
// Reset (i_rst_n, synchronous): all frames empty, ranks and fault count zero,
// frames_in_use = 3. A write to frames_in_use empties all frames.
`timescale 1ns / 1ps

module lru_page_replacement (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [lru_pkg::PAGE_W-1:0]  i_page,
    output logic                        o_done,
    output logic                        o_hit,
    output logic                        o_evicted_valid,
    output logic [lru_pkg::PAGE_W-1:0]  o_evicted_page,
    output logic [lru_pkg::FAULT_W-1:0] o_fault_count,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import lru_pkg::*;

    t_cfg              cfg;
    logic              r_in_valid;
    logic [PAGE_W-1:0] r_in_page;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in_page <= i_page;
        end
    end

    lru_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lru_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (r_in_valid),
        .i_page          (r_in_page),
        .o_done          (o_done),
        .o_hit           (o_hit),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_count   (o_fault_count)
    );

endmodule

// ===== tb/lru_page_replacement_tb.sv =====
// Self-checking testbench for the LRU page replacement block.
`timescale 1ns / 1ps

module lru_page_replacement_tb;

    import lru_pkg::*;

    localparam logic [2:0]  ADDR_FRAMES = {REG_FRAMES_IN_USE, 2'b00};
    localparam logic [2:0]  ADDR_UNUSED = {~REG_FRAMES_IN_USE, 2'b00};
    localparam logic [31:0] PAGE_MASK   = (32'd1 << PAGE_BITS) - 32'd1;
    localparam int          SAT_BURST   = 40;

    typedef struct {
        logic               hit;
        logic               ev_valid;
        logic [PAGE_W-1:0]  ev_page;
        logic [FAULT_W-1:0] faults;
    } t_access_outcome;

    // Mirror of the frame table; predicts the outcome of each accepted access.
    class t_lru_frame_tracker;
        logic [CFG_W-1:0]   cfg_frames;
        logic [PAGE_W-1:0]  page_of[FRAMES];
        bit                 resident[FRAMES];
        int                 recency[FRAMES];
        logic [FAULT_W-1:0] fault_total;
        t_access_outcome    expected_outcomes[$];
        int                 mismatches;
        int                 accesses;
        int                 hits;
        int                 evictions;
        int                 cfg_writes;

        function new();
            cfg_frames  = FIU_RESET;
            fault_total = '0;
            mismatches  = 0;
            accesses    = 0;
            hits        = 0;
            evictions   = 0;
            cfg_writes  = 0;
            flush();
        endfunction

        function void flush();
            for (int i = 0; i < FRAMES; i++) begin
                page_of[i]  = '0;
                resident[i] = 0;
                recency[i]  = 0;
            end
        endfunction

        function void write_reg(logic [2:0] addr, logic [31:0] data);
            if (addr == ADDR_FRAMES) begin
                cfg_frames = data[CFG_W-1:0];
                cfg_writes++;
                flush();
            end
        endfunction

        // age resident frames younger than bound, then make slot the newest
        function void promote(int lim, int slot, int bound);
            for (int i = 0; i < lim; i++)
                if (resident[i] && i != slot && recency[i] < bound)
                    recency[i]++;
            recency[slot] = 0;
        endfunction

        function void note_access(logic [PAGE_W-1:0] page_in);
            logic [PAGE_W-1:0] pg;
            int                lim;
            int                hit_slot;
            int                free_slot;
            int                victim;
            t_access_outcome   o;
            pg  = PAGE_W'(32'(page_in) & PAGE_MASK);
            lim = (cfg_frames == 0) ? 1 : (int'(cfg_frames) > FRAMES) ? FRAMES
                                                                        : int'(cfg_frames);
            hit_slot  = lim;
            free_slot = lim;
            victim    = lim;
            o = '{hit: 1'b0, ev_valid: 1'b0, ev_page: '0, faults: '0};
            for (int i = 0; i < lim; i++) begin
                if (resident[i]) begin
                    if (hit_slot == lim && page_of[i] == pg)
                        hit_slot = i;
                    if (victim == lim || recency[i] > recency[victim])
                        victim = i;
                end else if (free_slot == lim) begin
                    free_slot = i;
                end
            end
            if (hit_slot < lim) begin
                o.hit = 1'b1;
                hits++;
                promote(lim, hit_slot, recency[hit_slot]);
            end else begin
                if (fault_total != FAULT_MAX)
                    fault_total++;
                if (free_slot < lim) begin
                    page_of[free_slot]  = pg;
                    resident[free_slot] = 1;
                    promote(lim, free_slot, FRAMES + 1);
                end else if (victim < lim) begin
                    o.ev_valid      = 1'b1;
                    o.ev_page       = page_of[victim];
                    page_of[victim] = pg;
                    evictions++;
                    promote(lim, victim, recency[victim]);
                end
            end
            o.faults = fault_total;
            accesses++;
            expected_outcomes.push_back(o);
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] got);
            if (exp !== got) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, got);
                mismatches++;
            end
        endfunction

        function void check_outcome(logic hit, logic ev_valid, logic [PAGE_W-1:0] ev_page,
                                    logic [FAULT_W-1:0] faults);
            t_access_outcome e;
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %b %b %h %h",
                         $time, hit, ev_valid, ev_page, faults);
                mismatches++;
            end else begin
                e = expected_outcomes.pop_front();
                compare_field("hit", 32'(e.hit), 32'(hit));
                compare_field("evicted_valid", 32'(e.ev_valid), 32'(ev_valid));
                compare_field("evicted_page", 32'(e.ev_page), 32'(ev_page));
                compare_field("fault_count", 32'(e.faults), 32'(faults));
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [PAGE_W-1:0]  i_page;
    logic               o_done;
    logic               o_hit;
    logic               o_evicted_valid;
    logic [PAGE_W-1:0]  o_evicted_page;
    logic [FAULT_W-1:0] o_fault_count;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    t_lru_frame_tracker tracker = new();

    lru_page_replacement dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_page          (i_page),
        .o_done          (o_done),
        .o_hit           (o_hit),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_count   (o_fault_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sample handshakes with the values the block saw at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready)
                tracker.write_reg(paddr, pwdata);
            if (start && !busy)
                tracker.note_access(i_page);
            if (o_done)
                tracker.check_outcome(o_hit, o_evicted_valid, o_evicted_page, o_fault_count);
        end
    end

    task automatic send_page(input logic [PAGE_W-1:0] pg, input int gap_pct);
        if ($urandom_range(99) < gap_pct) begin
            start  <= 1'b0;
            i_page <= PAGE_W'($urandom);
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_page <= pg;
        do @(posedge i_clk); while (busy);
    endtask

    // stop sending and let every expected item come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.expected_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int                phase_cfg[8];
        logic [PAGE_W-1:0] pool[6];
        int                pool_n;
        int                gap;
        int                r;
        logic [31:0]       data;
        logic [PAGE_W-1:0] pg;

        phase_cfg = '{1, 4, 0, 2, 7, 3, 5, 6};
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_page  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting of three frames: fill, hit, evict the oldest
        send_page(16'h0000, 0);
        send_page(16'hFFFF, 0);
        send_page(16'h0001, 0);
        send_page(16'h0000, 0);
        send_page(16'h0002, 0);
        send_page(16'hFFFF, 0);
        send_page(16'h0002, 0);

        // zero frames behaves as one
        wait_drained();
        apb_write(ADDR_FRAMES, 32'd0);
        send_page(16'h0007, 0);
        send_page(16'h0007, 0);
        send_page(16'h0008, 0);

        // seven (upper bits set too) clamps to FRAMES
        wait_drained();
        apb_write(ADDR_FRAMES, 32'hFFFF_FFFF);
        send_page(16'h0001, 0);
        send_page(16'h0002, 0);
        send_page(16'h0003, 0);
        send_page(16'h0004, 0);
        send_page(16'h0001, 0);
        send_page(16'h0005, 0);
        send_page(16'h0003, 0);

        // write to a register that does not exist: frames must survive
        wait_drained();
        apb_write(ADDR_UNUSED, 32'h0000_0000);
        send_page(16'h0005, 0);
        send_page(16'hAAAA, 0);
        send_page(16'h5555, 0);

        // rewrite flushes: a resident page misses again
        wait_drained();
        apb_write(ADDR_FRAMES, 32'd4);
        send_page(16'h0005, 0);

        for (int p = 0; p < 8; p++) begin
            wait_drained();
            data = (p % 2 == 1) ? ($urandom & ~32'h7) : 32'h0;
            apb_write(ADDR_FRAMES, data | 32'(phase_cfg[p]));
            if (p == 5)
                apb_write(ADDR_UNUSED, $urandom);
            case (p % 4)
                1: gap = 77;
                2: gap = 20;
                default: gap = 0;
            endcase
            pool_n = $urandom_range(2, 6);
            foreach (pool[k])
                pool[k] = PAGE_W'($urandom);
            for (int n = 0; n < 100; n++) begin
                r = $urandom_range(99);
                if (r < 70)
                    pg = pool[$urandom_range(pool_n - 1)];
                else if (r < 85)
                    pg = pool[$urandom_range(pool_n - 1)]
                         ^ (PAGE_W'(1) << $urandom_range(PAGE_W - 1));
                else
                    pg = PAGE_W'($urandom);
                send_page(pg, gap);
            end
        end

        // one frame, two pages in turn: every access faults
        wait_drained();
        apb_write(ADDR_FRAMES, 32'd1);
        for (int n = 0; n < SAT_BURST; n++)
            send_page(n[0] ? 16'h1234 : 16'h4321, 0);
        wait_drained();
        apb_write(ADDR_FRAMES, 32'd2);
        for (int n = 0; n < 20; n++)
            send_page(PAGE_W'($urandom_range(3)), 77);

        wait_drained();
        tracker.mismatches += tracker.expected_outcomes.size();
        $display("Run covered %0d accesses (%0d hits, %0d evictions) over %0d frame settings,",
                 tracker.accesses, tracker.hits, tracker.evictions, tracker.cfg_writes);
        $display("frame counts 0 to 7, idle gaps, and a final fault count of %0d.",
                 tracker.fault_total);
        if (tracker.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
